// ===== hw/rtl/smlc_pkg.sv =====
// smlc_pkg: constants, codes and helper functions for the stencil min/max limiter
// no dependencies; imported by stencil_minmax_limiter_cells
`timescale 1ns / 1ps
`default_nettype none

package smlc_pkg;

	// grid side that the density store is built for
	localparam int MAX_SIDE = 32;
	localparam int SIDE_W   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
	localparam int SIZE_W   = $clog2(MAX_SIDE + 1);
	localparam int ADDR_W   = 3 * SIDE_W;
	localparam int GRID_DEPTH = 1 << ADDR_W;

	// fixed field widths
	localparam int DATA_W = 16;
	localparam int POS_W  = 20;
	localparam int INV_W  = 16;
	localparam int PROD_W = POS_W + INV_W + 1;
	// base cell after the Q.16 floor, with room for the stencil offset
	localparam int BASE_W = PROD_W + 1 - 16;
	localparam int CNT_W  = 3;

	typedef logic signed [BASE_W-1:0] base_t;
	typedef logic signed [BASE_W:0]   sum_t;
	typedef logic [SIZE_W-1:0]        size_t;
	typedef logic [SIDE_W-1:0]        idx_t;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// stencil modes
	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_WENO4  = 2'd1;
	localparam logic [1:0] MODE_WENO6  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_STENCIL_MODE = 3'd0;
	localparam logic [2:0] REG_SIZE_X       = 3'd1;
	localparam logic [2:0] REG_SIZE_Y       = 3'd2;
	localparam logic [2:0] REG_SIZE_Z       = 3'd3;
	localparam logic [2:0] REG_INV_CELL_LEN = 3'd4;

	// size register as used: at least 2, at most MAX_SIDE
	function automatic size_t eff_size(input logic [5:0] s);
		logic [7:0] s8;
		s8 = {2'b00, s};
		if (s8 < 8'd2) begin
			return SIZE_W'(2);
		end else if (s8 > 8'(MAX_SIDE)) begin
			return SIZE_W'(MAX_SIDE);
		end
		return SIZE_W'(s8);
	endfunction

	// linear mode base clamp to 0..n-2
	function automatic base_t clamp_lin(input base_t b, input size_t n);
		base_t hi;
		hi = BASE_W'($signed({1'b0, n})) - BASE_W'(2);
		if (b < 0) begin
			return '0;
		end else if (b > hi) begin
			return hi;
		end
		return b;
	endfunction

	// stencil index clamp to 0..n-1
	function automatic idx_t clamp_idx(input sum_t v, input size_t n);
		sum_t hi;
		hi = (BASE_W + 1)'($signed({1'b0, n})) - (BASE_W + 1)'(1);
		if (v < 0) begin
			return '0;
		end else if (v > hi) begin
			return hi[SIDE_W-1:0];
		end
		return v[SIDE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smlc_ram.sv =====
// smlc_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies; holds the density grid of the limiter
`timescale 1ns / 1ps
`default_nettype none

module smlc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/stencil_minmax_limiter_cells.sv =====
// stencil_minmax_limiter_cells: advection clamp limiter over a stored 3d density grid
// depends on smlc_pkg and smlc_ram
`timescale 1ns / 1ps
`default_nettype none

// channel   side   handshake              beat payload
// in        sink   in_valid / in_stall    cmd, cell_x/y/z, cell_value, advected_value,
//                                         pos_x/y/z
// out       source out_valid / out_stall  clamped_value
// cfg       sink   cfg_write              cfg_index, cfg_data
//
// a write beat stores the grid entry at the accepting edge
// a query runs the multiply, base, sweep, drain and finish states; its sweep reads
// span^3 entries (span 2, 4 or 6) over the one grid read port, one entry per cycle
// one query is worked at a time; in_stall is high from accept until the result
// sits in the output register, which frees the input while the result waits
// reset clears control and configuration; the grid is undefined until written

module stencil_minmax_limiter_cells
	import smlc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_write,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [15:0]              cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     cmd,
	input  wire logic [4:0]               cell_x,
	input  wire logic [4:0]               cell_y,
	input  wire logic [4:0]               cell_z,
	input  wire logic signed [DATA_W-1:0] cell_value,
	input  wire logic signed [DATA_W-1:0] advected_value,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic signed [POS_W-1:0]  pos_z,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      clamped_value
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BASE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]        mode_q;
	size_t             nx_q, ny_q, nz_q;
	logic [INV_W-1:0]  inv_q;

	// query operands and working values
	logic signed [DATA_W-1:0] adv_q;
	logic signed [POS_W-1:0]  px_q, py_q, pz_q;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q, prod_z_q;
	base_t                    start_x_q, start_y_q, start_z_q;
	logic [CNT_W-1:0]         span_q;
	logic [CNT_W-1:0]         i_q, j_q, k_q;
	logic signed [DATA_W-1:0] lo_q, hi_q;

	// read pipeline tags
	logic rd_vld_s1;
	logic rd_first_s1;

	logic in_acc;
	logic out_acc;
	logic mem_we;
	logic mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic [7:0] wx8, wy8, wz8;
	logic in_range;
	logic sweep_first, sweep_last;
	idx_t cx, cy, cz;
	base_t bx, by, bz;
	logic signed [DATA_W-1:0] rd_d;
	logic signed [DATA_W-1:0] res_val;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	// grid store: writes only in idle, reads only in the sweep, so no overlap
	assign wx8 = {3'b000, cell_x};
	assign wy8 = {3'b000, cell_y};
	assign wz8 = {3'b000, cell_z};
	assign in_range = (wx8 < 8'(MAX_SIDE)) && (wy8 < 8'(MAX_SIDE)) && (wz8 < 8'(MAX_SIDE));
	assign mem_we    = in_acc && (cmd == CMD_WRITE) && in_range;
	assign mem_waddr = {wx8[SIDE_W-1:0], wy8[SIDE_W-1:0], wz8[SIDE_W-1:0]};

	// stencil index for the current counter position, clamped into the grid
	assign cx = clamp_idx(sum_t'(start_x_q) + sum_t'({1'b0, i_q}), nx_q);
	assign cy = clamp_idx(sum_t'(start_y_q) + sum_t'({1'b0, j_q}), ny_q);
	assign cz = clamp_idx(sum_t'(start_z_q) + sum_t'({1'b0, k_q}), nz_q);
	assign mem_re    = (state_q == ST_SWEEP);
	assign mem_raddr = {cx, cy, cz};

	assign sweep_first = (i_q == '0) && (j_q == '0) && (k_q == '0);
	assign sweep_last  = (i_q == span_q - CNT_W'(1)) && (j_q == span_q - CNT_W'(1))
		&& (k_q == span_q - CNT_W'(1));

	smlc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (GRID_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (cell_value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// floor(p - 0.5) in Q.16: subtract one half, keep the upper bits
	function automatic base_t floor_base(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = (PROD_W + 1)'(p) - (PROD_W + 1)'(32768);
		return t[PROD_W:16];
	endfunction

	assign bx = floor_base(prod_x_q);
	assign by = floor_base(prod_y_q);
	assign bz = floor_base(prod_z_q);

	assign rd_d = $signed(mem_rdata);

	// final limit of the advected value
	always_comb begin
		res_val = adv_q;
		if (res_val > hi_q) begin
			res_val = hi_q;
		end
		if (res_val < lo_q) begin
			res_val = lo_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			nx_q   <= eff_size(6'd32);
			ny_q   <= eff_size(6'd32);
			nz_q   <= eff_size(6'd32);
			inv_q  <= INV_W'(256);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STENCIL_MODE: mode_q <= cfg_data[1:0];
				REG_SIZE_X:       nx_q   <= eff_size(cfg_data[5:0]);
				REG_SIZE_Y:       ny_q   <= eff_size(cfg_data[5:0]);
				REG_SIZE_Z:       nz_q   <= eff_size(cfg_data[5:0]);
				REG_INV_CELL_LEN: inv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: state, counters, read tags and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			rd_vld_s1     <= 1'b0;
			rd_first_s1   <= 1'b0;
			out_valid     <= 1'b0;
			clamped_value <= '0;
		end else begin
			rd_vld_s1   <= mem_re;
			rd_first_s1 <= mem_re && sweep_first;
			// the finish step reloads the output register on its own
			if (out_acc && (state_q != ST_FINISH)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (cmd == CMD_QUERY)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					// z runs fastest, then y, then x
					if (sweep_last) begin
						state_q <= ST_DRAIN;
					end else if (k_q != span_q - CNT_W'(1)) begin
						k_q <= k_q + CNT_W'(1);
					end else begin
						k_q <= '0;
						if (j_q != span_q - CNT_W'(1)) begin
							j_q <= j_q + CNT_W'(1);
						end else begin
							j_q <= '0;
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						clamped_value <= res_val;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			adv_q <= advected_value;
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
		end
		if (state_q == ST_MUL) begin
			prod_x_q <= px_q * $signed({1'b0, inv_q});
			prod_y_q <= py_q * $signed({1'b0, inv_q});
			prod_z_q <= pz_q * $signed({1'b0, inv_q});
		end
		if (state_q == ST_BASE) begin
			case (mode_q)
				MODE_WENO4: begin
					start_x_q <= bx - BASE_W'(1);
					start_y_q <= by - BASE_W'(1);
					start_z_q <= bz - BASE_W'(1);
					span_q    <= CNT_W'(4);
				end
				MODE_WENO6: begin
					start_x_q <= bx - BASE_W'(2);
					start_y_q <= by - BASE_W'(2);
					start_z_q <= bz - BASE_W'(2);
					span_q    <= CNT_W'(6);
				end
				default: begin
					// linear, and the unused mode code
					start_x_q <= clamp_lin(bx, nx_q);
					start_y_q <= clamp_lin(by, ny_q);
					start_z_q <= clamp_lin(bz, nz_q);
					span_q    <= CNT_W'(2);
				end
			endcase
		end
		// running min and max over the returning stencil entries
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				lo_q <= rd_d;
				hi_q <= rd_d;
			end else begin
				if (rd_d < lo_q) begin
					lo_q <= rd_d;
				end
				if (rd_d > hi_q) begin
					hi_q <= rd_d;
				end
			end
		end
	end

	// grid is never written while a stencil read is in flight
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("grid write during stencil sweep");

	// read data only comes back in the cycle after a sweep cycle
	a_read_follows_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> rd_vld_s1)
		else $error("stencil read tag lost");

	// a new result only appears from the finish step
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result without finished stencil");

	// the min/max window is ordered when the limit is applied
	a_window_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (lo_q <= hi_q))
		else $error("stencil min above max");

endmodule

`default_nettype wire
